FILE: rtl/cms_pkg.sv
// Shared types, codes and defaults for the curtain motion sequencer.
package cms_pkg;

	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned LINK_DEPTH  = 2;

	localparam logic [31:0] UP_TO_OPEN_RESET     = 32'd10000000;
	localparam logic [31:0] CLOSED_TO_OPEN_RESET = 32'd5000000;
	localparam logic [19:0] STEP_RATE_RESET      = 20'd100;

	// configuration register indexes
	localparam logic [1:0] REG_UP_TO_OPEN     = 2'd0;
	localparam logic [1:0] REG_CLOSED_TO_OPEN = 2'd1;
	localparam logic [1:0] REG_STEP_RATE      = 2'd2;

	// event codes on the action field
	localparam logic [2:0] ACT_TARGET  = 3'd0;
	localparam logic [2:0] ACT_COUNTED = 3'd1;
	localparam logic [2:0] ACT_UPPER   = 3'd2;
	localparam logic [2:0] ACT_LOWER   = 3'd3;
	localparam logic [2:0] ACT_DONE    = 3'd4;
	localparam logic [2:0] ACT_UPDATE  = 3'd5;
	localparam logic [2:0] ACT_STOP    = 3'd6;

	localparam logic [1:0] POS_UNKNOWN = 2'd0;
	localparam logic [1:0] POS_UP      = 2'd1;
	localparam logic [1:0] POS_OPEN    = 2'd2;
	localparam logic [1:0] POS_CLOSED  = 2'd3;

	localparam logic DIR_FWD = 1'b0;
	localparam logic DIR_REV = 1'b1;

	localparam logic [1:0] CMD_NONE  = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_COUNT = 2'd2;
	localparam logic [1:0] CMD_STOP  = 2'd3;

	localparam logic [1:0] RES_OK      = 2'd0;
	localparam logic [1:0] RES_INVALID = 2'd1;
	localparam logic [1:0] RES_FULL    = 2'd2;

	localparam logic [1:0] KIND_NONE     = 2'd0;
	localparam logic [1:0] KIND_TO_LIMIT = 2'd1;
	localparam logic [1:0] KIND_STEPS    = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [1:0]  target_state;
		logic        direction;
		logic [31:0] step_count;
	} event_t;

	typedef struct packed {
		logic [1:0]  result_code;
		logic [1:0]  motor_command;
		logic        motor_direction;
		logic [31:0] motor_steps;
		logic [19:0] motor_rate;
		logic [1:0]  position;
		logic        moving;
		logic [2:0]  free_slots;
	} result_t;

	typedef enum logic [2:0] {
		EV_NOP,
		EV_TARGET,
		EV_COUNTED,
		EV_LIMIT,
		EV_DONE,
		EV_UPDATE,
		EV_STOP
	} ev_cls_t;

	// classified event handed from front to back
	typedef struct packed {
		ev_cls_t     cls;
		logic        limit_up;
		logic        steps_zero;
		logic [1:0]  target;
		logic        dir;
		logic [31:0] steps;
	} ev_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        dir;
		logic [31:0] steps;
		logic [1:0]  final_pos;
	} motion_t;

	localparam motion_t MOTION_CLEAR = '{KIND_NONE, DIR_FWD, 32'd0, POS_UNKNOWN};

endpackage

FILE: rtl/curtain_motion_sequencer_core.sv
// Curtain motion sequencer: front decode, event queue, back end and result queue.
// An item waits in the event queue; its result is then registered in the result queue.
// Throughput: one item per cycle while the result queue has room, set by the back end.
// The event and result queues let either side stall without stopping the other.
// Reset (arst_n low) empties both queues and the action queue, clears the motion state
// and loads the configuration registers with their default values.
module curtain_motion_sequencer_core #(
	parameter int unsigned QUEUE_DEPTH = cms_pkg::QUEUE_DEPTH,
	parameter int unsigned LINK_DEPTH  = cms_pkg::LINK_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  cms_pkg::event_t  event_item,
	output logic             empty,
	input  logic             pop,
	output cms_pkg::result_t result_item,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data
);

	localparam logic [2:0] FREE_ALL = 3'(QUEUE_DEPTH);

	cms_pkg::ev_t     dec_item;
	cms_pkg::ev_t     ev_item;
	logic             ev_valid;
	logic             ev_pop;
	logic             res_full;
	logic             res_wr;
	logic             res_valid;
	cms_pkg::result_t res_item;

	assign cfg_ready = 1'b1;
	assign empty     = !res_valid;

	cms_front u_front (
		.event_item (event_item),
		.ev_item    (dec_item)
	);

	cms_fifo #(
		.item_t (cms_pkg::ev_t),
		.DEPTH  (LINK_DEPTH)
	) u_evq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (push),
		.wr_item (dec_item),
		.full    (full),
		.rd      (ev_pop),
		.rd_item (ev_item),
		.valid   (ev_valid)
	);

	cms_back #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.ev_valid  (ev_valid),
		.ev_item   (ev_item),
		.ev_pop    (ev_pop),
		.res_full  (res_full),
		.res_wr    (res_wr),
		.res_item  (res_item)
	);

	cms_fifo #(
		.item_t (cms_pkg::result_t),
		.DEPTH  (LINK_DEPTH)
	) u_resq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (res_wr),
		.wr_item (res_item),
		.full    (res_full),
		.rd      (pop),
		.rd_item (result_item),
		.valid   (res_valid)
	);

	// back end never retires an event it cannot hand on
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		res_wr |-> (ev_valid && !res_full))
		else $error("result written without room or event");

	// an accepted item is waiting for the back end at the next edge
	a_ev_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !full) |=> ev_valid)
		else $error("accepted item missing from event queue");

	// idle means the action queue is empty
	a_idle_free: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && !res_item.moving) |-> (res_item.free_slots == FREE_ALL))
		else $error("idle with queued actions");

	// a queue-full reject issues no motor command
	a_full_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_wr && (res_item.result_code == cms_pkg::RES_FULL)) |->
		(res_item.motor_command == cms_pkg::CMD_NONE))
		else $error("motor command on rejected request");

endmodule

FILE: rtl/cms_front.sv
// Front end: decodes an incoming event into its class and flags.
module cms_front (
	input  cms_pkg::event_t event_item,
	output cms_pkg::ev_t    ev_item
);

	always_comb begin
		ev_item.limit_up   = (event_item.action == cms_pkg::ACT_UPPER);
		ev_item.steps_zero = (event_item.step_count == 32'd0);
		ev_item.target     = event_item.target_state;
		ev_item.dir        = event_item.direction;
		ev_item.steps      = event_item.step_count;
		unique case (event_item.action)
			cms_pkg::ACT_TARGET:  ev_item.cls = cms_pkg::EV_TARGET;
			cms_pkg::ACT_COUNTED: ev_item.cls = cms_pkg::EV_COUNTED;
			cms_pkg::ACT_UPPER:   ev_item.cls = cms_pkg::EV_LIMIT;
			cms_pkg::ACT_LOWER:   ev_item.cls = cms_pkg::EV_LIMIT;
			cms_pkg::ACT_DONE:    ev_item.cls = cms_pkg::EV_DONE;
			cms_pkg::ACT_UPDATE:  ev_item.cls = cms_pkg::EV_UPDATE;
			cms_pkg::ACT_STOP:    ev_item.cls = cms_pkg::EV_STOP;
			default:              ev_item.cls = cms_pkg::EV_NOP;
		endcase
	end

endmodule

FILE: rtl/cms_fifo.sv
// Small first-in first-out buffer used between the stages.
module cms_fifo #(
	parameter type         item_t = logic,
	parameter int unsigned DEPTH  = cms_pkg::LINK_DEPTH
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  item_t wr_item,
	output logic  full,
	input  logic  rd,
	output item_t rd_item,
	output logic  valid
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	item_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en;
	logic          rd_en;

	assign full    = (count_q == CW'(DEPTH));
	assign valid   = (count_q != '0);
	assign wr_en   = wr && !full;
	assign rd_en   = rd && valid;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/cms_back.sv
// Back end: motion state, action queue, configuration and result building.
module cms_back #(
	parameter int unsigned QUEUE_DEPTH = cms_pkg::QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_valid,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	input  logic             ev_valid,
	input  cms_pkg::ev_t     ev_item,
	output logic             ev_pop,
	input  logic             res_full,
	output logic             res_wr,
	output cms_pkg::result_t res_item
);

	localparam int unsigned QW  = $clog2(QUEUE_DEPTH);
	localparam int unsigned QCW = $clog2(QUEUE_DEPTH + 1);

	logic [31:0] up_to_open_q;
	logic [31:0] closed_to_open_q;
	logic [19:0] step_rate_q;

	logic [1:0]       pos_q, pos_d;
	logic             act_q, act_d;
	logic             done_q, done_d;
	cms_pkg::motion_t rec_q, rec_d;
	cms_pkg::motion_t store_q [QUEUE_DEPTH];
	logic [QW-1:0]    head_q, head_d;
	logic [QW-1:0]    tail_q, tail_d;
	logic [QCW-1:0]   count_q, count_d;

	logic [QW-1:0]    tail_n1, tail_n2, head_n1;
	logic [QCW-1:0]   free_now, free_d;
	logic [QCW+2:0]   free_x;
	logic             need_two;
	logic             upd_active;
	logic             wr1, wr2;
	cms_pkg::motion_t rec1, rec2, head_rec;
	logic             go;

	assign go      = ev_valid && !res_full;
	assign ev_pop  = go;
	assign res_wr  = go;

	assign tail_n1  = (tail_q == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + 1'b1;
	assign tail_n2  = (tail_n1 == QW'(QUEUE_DEPTH - 1)) ? '0 : tail_n1 + 1'b1;
	assign head_n1  = (head_q == QW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign head_rec = store_q[head_q];
	assign free_now = QCW'(QUEUE_DEPTH) - count_q;
	// open from anywhere but up or closed goes via the lower limit first
	assign need_two = (ev_item.target == cms_pkg::POS_OPEN) &&
		(pos_q != cms_pkg::POS_UP) && (pos_q != cms_pkg::POS_CLOSED);

	always_comb begin
		pos_d      = pos_q;
		act_d      = act_q;
		done_d     = done_q;
		rec_d      = rec_q;
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		upd_active = act_q;
		wr1        = 1'b0;
		wr2        = 1'b0;
		rec1       = cms_pkg::MOTION_CLEAR;
		rec2       = cms_pkg::MOTION_CLEAR;
		res_item.result_code     = cms_pkg::RES_OK;
		res_item.motor_command   = cms_pkg::CMD_NONE;
		res_item.motor_direction = 1'b0;
		res_item.motor_steps     = 32'd0;
		res_item.motor_rate      = 20'd0;

		unique case (ev_item.cls)
			cms_pkg::EV_TARGET: begin
				if (pos_q == ev_item.target) begin
					res_item.result_code = cms_pkg::RES_INVALID;
				end else if (free_now < (need_two ? QCW'(2) : QCW'(1))) begin
					res_item.result_code = cms_pkg::RES_FULL;
				end else if (ev_item.target == cms_pkg::POS_UNKNOWN) begin
					res_item.result_code = cms_pkg::RES_INVALID;
				end else begin
					wr1 = 1'b1;
					priority if (ev_item.target == cms_pkg::POS_UP) begin
						rec1 = '{cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_REV, 32'd0,
							cms_pkg::POS_UP};
					end else if (ev_item.target == cms_pkg::POS_CLOSED) begin
						rec1 = '{cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_FWD, 32'd0,
							cms_pkg::POS_CLOSED};
					end else if (pos_q == cms_pkg::POS_UP) begin
						rec1 = '{cms_pkg::KIND_STEPS, cms_pkg::DIR_FWD, up_to_open_q,
							cms_pkg::POS_OPEN};
					end else if (pos_q == cms_pkg::POS_CLOSED) begin
						rec1 = '{cms_pkg::KIND_STEPS, cms_pkg::DIR_REV, closed_to_open_q,
							cms_pkg::POS_OPEN};
					end else begin
						rec1 = '{cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_FWD, 32'd0,
							cms_pkg::POS_CLOSED};
						rec2 = '{cms_pkg::KIND_STEPS, cms_pkg::DIR_REV, closed_to_open_q,
							cms_pkg::POS_OPEN};
						wr2  = 1'b1;
					end
					tail_d  = wr2 ? tail_n2 : tail_n1;
					count_d = count_q + (wr2 ? QCW'(2) : QCW'(1));
				end
			end
			cms_pkg::EV_COUNTED: begin
				if (ev_item.steps_zero) begin
					res_item.result_code = cms_pkg::RES_INVALID;
				end else if (free_now == '0) begin
					res_item.result_code = cms_pkg::RES_FULL;
				end else begin
					wr1     = 1'b1;
					rec1    = '{cms_pkg::KIND_STEPS, ev_item.dir, ev_item.steps,
						cms_pkg::POS_UNKNOWN};
					tail_d  = tail_n1;
					count_d = count_q + 1'b1;
				end
			end
			cms_pkg::EV_LIMIT: begin
				// only a move heading toward this limit is stopped
				if (act_q && (rec_q.dir == (ev_item.limit_up ? cms_pkg::DIR_REV :
					cms_pkg::DIR_FWD))) begin
					res_item.motor_command = cms_pkg::CMD_STOP;
					rec_d.final_pos = ev_item.limit_up ? cms_pkg::POS_UP :
						cms_pkg::POS_CLOSED;
					done_d = 1'b1;
				end
			end
			cms_pkg::EV_DONE: begin
				done_d = 1'b1;
			end
			cms_pkg::EV_UPDATE: begin
				if (done_q) begin
					done_d     = 1'b0;
					upd_active = 1'b0;
					pos_d      = rec_q.final_pos;
					rec_d      = cms_pkg::MOTION_CLEAR;
				end
				act_d = upd_active;
				if (!upd_active && (count_q != '0)) begin
					head_d  = head_n1;
					count_d = count_q - 1'b1;
					if ((head_rec.kind == cms_pkg::KIND_TO_LIMIT) ||
						(head_rec.kind == cms_pkg::KIND_STEPS)) begin
						rec_d = head_rec;
						res_item.motor_command = (head_rec.kind == cms_pkg::KIND_TO_LIMIT) ?
							cms_pkg::CMD_RUN : cms_pkg::CMD_COUNT;
						res_item.motor_direction = head_rec.dir;
						res_item.motor_steps = (head_rec.kind == cms_pkg::KIND_STEPS) ?
							head_rec.steps : 32'd0;
						res_item.motor_rate = step_rate_q;
						pos_d = cms_pkg::POS_UNKNOWN;
						act_d = 1'b1;
					end else begin
						rec_d = cms_pkg::MOTION_CLEAR;
						res_item.result_code = cms_pkg::RES_INVALID;
					end
				end
			end
			cms_pkg::EV_STOP: begin
				res_item.motor_command = cms_pkg::CMD_STOP;
				head_d  = '0;
				tail_d  = '0;
				count_d = '0;
				rec_d   = cms_pkg::MOTION_CLEAR;
				done_d  = 1'b0;
				act_d   = 1'b0;
				pos_d   = ev_item.target;
			end
			default: begin
			end
		endcase

		free_d              = QCW'(QUEUE_DEPTH) - count_d;
		free_x              = {3'b000, free_d};
		res_item.position   = pos_d;
		res_item.moving     = act_d || (count_d != '0);
		res_item.free_slots = free_x[2:0];
	end

	always_ff @(posedge clk) begin
		if (go && wr1) begin
			store_q[tail_q] <= rec1;
		end
		if (go && wr2) begin
			store_q[tail_n1] <= rec2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_to_open_q     <= cms_pkg::UP_TO_OPEN_RESET;
			closed_to_open_q <= cms_pkg::CLOSED_TO_OPEN_RESET;
			step_rate_q      <= cms_pkg::STEP_RATE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				cms_pkg::REG_UP_TO_OPEN:     up_to_open_q     <= cfg_data;
				cms_pkg::REG_CLOSED_TO_OPEN: closed_to_open_q <= cfg_data;
				cms_pkg::REG_STEP_RATE:      step_rate_q      <= cfg_data[19:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= cms_pkg::POS_UNKNOWN;
			act_q   <= 1'b0;
			done_q  <= 1'b0;
			rec_q   <= cms_pkg::MOTION_CLEAR;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (go) begin
			pos_q   <= pos_d;
			act_q   <= act_d;
			done_q  <= done_d;
			rec_q   <= rec_d;
			head_q  <= head_d;
			tail_q  <= tail_d;
			count_q <= count_d;
		end
	end

endmodule

FILE: bench/tb.sv
// Self-checking bench for the curtain motion sequencer: queued event driver, result monitor.
`timescale 1ns / 1ps

module tb;

	typedef struct packed {
		logic [1:0]  idx;
		logic [31:0] val;
	} reg_write_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             push = 1'b0;
	logic             full;
	cms_pkg::event_t  ev_drive = '0;
	logic             empty;
	logic             pop = 1'b0;
	cms_pkg::result_t result_item;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [1:0]       cfg_index = '0;
	logic [31:0]      cfg_data = '0;

	curtain_motion_sequencer_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.event_item(ev_drive),
		.empty(empty),
		.pop(pop),
		.result_item(result_item),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#4000000;
		$display("Regression FAIL");
		$finish;
	end

	cms_pkg::event_t  pending_q[$];
	cms_pkg::result_t expect_q[$];
	reg_write_t       reg_writes_q[$];
	int               errors = 0;
	int               queued_items = 0;
	int               send_gap = 0;
	int               sink_gap = 0;
	bit               calm = 1'b0;

	// shadow of the sequencer state
	logic [1:0]       cur_pos;
	logic             run_busy;
	logic             run_done;
	cms_pkg::motion_t run_rec;
	cms_pkg::motion_t plan_store[cms_pkg::QUEUE_DEPTH];
	logic [1:0]       plan_head;
	logic [1:0]       plan_tail;
	logic [2:0]       plan_count;
	logic [31:0]      cfg_up_open;
	logic [31:0]      cfg_closed_open;
	logic [19:0]      cfg_rate;

	function automatic cms_pkg::motion_t plan_entry(logic [1:0] kind, logic dir,
			logic [31:0] steps, logic [1:0] fin);
		cms_pkg::motion_t m;
		m.kind = kind;
		m.dir = dir;
		m.steps = steps;
		m.final_pos = fin;
		return m;
	endfunction

	function automatic void enqueue_plan(cms_pkg::motion_t m);
		if (plan_count < cms_pkg::QUEUE_DEPTH) begin
			plan_store[plan_tail] = m;
			plan_tail++;
			plan_count++;
		end
	endfunction

	function automatic cms_pkg::result_t predict_outcome(cms_pkg::event_t ev);
		cms_pkg::result_t r;
		logic [2:0]       room;
		logic [2:0]       need;
		logic             toward;
		r = '0;
		room = 3'(cms_pkg::QUEUE_DEPTH - plan_count);
		need = 3'd1;
		case (ev.action)
			cms_pkg::ACT_TARGET: begin
				if (cur_pos == ev.target_state) begin
					r.result_code = cms_pkg::RES_INVALID;
				end else begin
					if (ev.target_state == cms_pkg::POS_OPEN && cur_pos != cms_pkg::POS_UP &&
						cur_pos != cms_pkg::POS_CLOSED)
						need = 3'd2;
					// room is checked ahead of the unknown-target test
					if (room < need) begin
						r.result_code = cms_pkg::RES_FULL;
					end else if (ev.target_state == cms_pkg::POS_UNKNOWN) begin
						r.result_code = cms_pkg::RES_INVALID;
					end else if (ev.target_state == cms_pkg::POS_UP) begin
						enqueue_plan(plan_entry(cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_REV, 32'd0,
							cms_pkg::POS_UP));
					end else if (ev.target_state == cms_pkg::POS_CLOSED) begin
						enqueue_plan(plan_entry(cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_FWD, 32'd0,
							cms_pkg::POS_CLOSED));
					end else if (cur_pos == cms_pkg::POS_UP) begin
						enqueue_plan(plan_entry(cms_pkg::KIND_STEPS, cms_pkg::DIR_FWD, cfg_up_open,
							cms_pkg::POS_OPEN));
					end else if (cur_pos == cms_pkg::POS_CLOSED) begin
						enqueue_plan(plan_entry(cms_pkg::KIND_STEPS, cms_pkg::DIR_REV,
							cfg_closed_open, cms_pkg::POS_OPEN));
					end else begin
						enqueue_plan(plan_entry(cms_pkg::KIND_TO_LIMIT, cms_pkg::DIR_FWD, 32'd0,
							cms_pkg::POS_CLOSED));
						enqueue_plan(plan_entry(cms_pkg::KIND_STEPS, cms_pkg::DIR_REV,
							cfg_closed_open, cms_pkg::POS_OPEN));
					end
				end
			end
			cms_pkg::ACT_COUNTED: begin
				if (ev.step_count == 32'd0)
					r.result_code = cms_pkg::RES_INVALID;
				else if (room == 3'd0)
					r.result_code = cms_pkg::RES_FULL;
				else
					enqueue_plan(plan_entry(cms_pkg::KIND_STEPS, ev.direction, ev.step_count,
						cms_pkg::POS_UNKNOWN));
			end
			cms_pkg::ACT_UPPER, cms_pkg::ACT_LOWER: begin
				toward = (ev.action == cms_pkg::ACT_UPPER) ? cms_pkg::DIR_REV : cms_pkg::DIR_FWD;
				if (run_busy && run_rec.dir == toward) begin
					r.motor_command = cms_pkg::CMD_STOP;
					run_rec.final_pos = (ev.action == cms_pkg::ACT_UPPER) ? cms_pkg::POS_UP :
						cms_pkg::POS_CLOSED;
					run_done = 1'b1;
				end
			end
			cms_pkg::ACT_DONE: begin
				run_done = 1'b1;
			end
			cms_pkg::ACT_UPDATE: begin
				if (run_done) begin
					run_done = 1'b0;
					run_busy = 1'b0;
					cur_pos = run_rec.final_pos;
					run_rec = cms_pkg::MOTION_CLEAR;
				end
				if (!run_busy && plan_count > 0) begin
					run_rec = plan_store[plan_head];
					plan_head++;
					plan_count--;
					if (run_rec.kind == cms_pkg::KIND_TO_LIMIT ||
						run_rec.kind == cms_pkg::KIND_STEPS) begin
						r.motor_command = (run_rec.kind == cms_pkg::KIND_TO_LIMIT) ?
							cms_pkg::CMD_RUN : cms_pkg::CMD_COUNT;
						r.motor_direction = run_rec.dir;
						r.motor_steps = (run_rec.kind == cms_pkg::KIND_STEPS) ? run_rec.steps :
							32'd0;
						r.motor_rate = cfg_rate;
						cur_pos = cms_pkg::POS_UNKNOWN;
						run_busy = 1'b1;
					end else begin
						run_rec = cms_pkg::MOTION_CLEAR;
						r.result_code = cms_pkg::RES_INVALID;
					end
				end
			end
			cms_pkg::ACT_STOP: begin
				r.motor_command = cms_pkg::CMD_STOP;
				plan_head = '0;
				plan_tail = '0;
				plan_count = '0;
				run_rec = cms_pkg::MOTION_CLEAR;
				run_done = 1'b0;
				run_busy = 1'b0;
				cur_pos = ev.target_state;
			end
			default: ;
		endcase
		r.position = cur_pos;
		r.moving = run_busy || plan_count > 0;
		r.free_slots = 3'(cms_pkg::QUEUE_DEPTH - plan_count);
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		errors++;
	endtask

	task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
	endtask

	task automatic check_result(cms_pkg::result_t got);
		cms_pkg::result_t want;
		if (expect_q.size() == 0) begin
			report_mismatch("result arrived with no item outstanding");
		end else begin
			want = expect_q.pop_front();
			check_field("result_code", 32'(got.result_code), 32'(want.result_code));
			check_field("motor_command", 32'(got.motor_command), 32'(want.motor_command));
			check_field("motor_direction", 32'(got.motor_direction), 32'(want.motor_direction));
			check_field("motor_steps", got.motor_steps, want.motor_steps);
			check_field("motor_rate", 32'(got.motor_rate), 32'(want.motor_rate));
			check_field("position", 32'(got.position), 32'(want.position));
			check_field("moving", 32'(got.moving), 32'(want.moving));
			check_field("free_slots", 32'(got.free_slots), 32'(want.free_slots));
		end
	endtask

	// event driver
	always @(posedge clk) begin
		if (!arst_n) begin
			push <= 1'b0;
		end else begin
			if (push && !full)
				expect_q.push_back(predict_outcome(ev_drive));
			if (!(push && full)) begin
				if (send_gap > 0) begin
					send_gap--;
					push <= 1'b0;
				end else if (pending_q.size() == 0) begin
					push <= 1'b0;
				end else if (!calm && $urandom_range(0, 7) == 0) begin
					send_gap = $urandom_range(0, 10);
					push <= 1'b0;
				end else begin
					push <= 1'b1;
					ev_drive <= pending_q.pop_front();
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty)
				check_result(result_item);
			if (sink_gap > 0) begin
				sink_gap--;
				pop <= 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(0, 10);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// register writes
	always @(posedge clk) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cms_pkg::REG_UP_TO_OPEN:     cfg_up_open = cfg_data;
					cms_pkg::REG_CLOSED_TO_OPEN: cfg_closed_open = cfg_data;
					cms_pkg::REG_STEP_RATE:      cfg_rate = cfg_data[19:0];
					default: ;
				endcase
			end
			if (!(cfg_valid && !cfg_ready)) begin
				if (reg_writes_q.size() != 0) begin
					reg_write_t w;
					w = reg_writes_q.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.idx;
					cfg_data <= w.val;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	task automatic add_event(logic [2:0] action, logic [1:0] target, logic dir,
			logic [31:0] steps);
		cms_pkg::event_t ev;
		ev.action = action;
		ev.target_state = target;
		ev.direction = dir;
		ev.step_count = steps;
		pending_q.push_back(ev);
		queued_items++;
	endtask

	function automatic logic [31:0] rand_steps();
		case ($urandom_range(0, 3))
			0: return 32'd0;
			1: return '1;
			2: return 32'($urandom_range(1, 20));
			default: return $urandom;
		endcase
	endfunction

	// finish of the active move: motor done or a random limit hit, then update
	task automatic add_move_finish();
		case ($urandom_range(0, 2))
			0: add_event(cms_pkg::ACT_DONE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				$urandom);
			1: add_event(cms_pkg::ACT_UPPER, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
				$urandom);
			default: add_event(cms_pkg::ACT_LOWER, 2'($urandom_range(0, 3)),
				1'($urandom_range(0, 1)), $urandom);
		endcase
		add_event(cms_pkg::ACT_UPDATE, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
			$urandom);
	endtask

	task automatic add_random_events(int count);
		int goal;
		goal = queued_items + count;
		while (queued_items < goal) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: begin
					add_event(cms_pkg::ACT_TARGET, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), $urandom);
					add_event(cms_pkg::ACT_UPDATE, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), $urandom);
					add_move_finish();
					if ($urandom_range(0, 1) == 1)
						add_move_finish();
				end
				4: begin
					add_event(cms_pkg::ACT_COUNTED, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), rand_steps());
					add_event(cms_pkg::ACT_UPDATE, 2'($urandom_range(0, 3)),
						1'($urandom_range(0, 1)), $urandom);
					add_move_finish();
				end
				5: begin
					// pile up requests to reach a full action queue
					repeat ($urandom_range(3, 5)) begin
						if ($urandom_range(0, 1) == 1)
							add_event(cms_pkg::ACT_TARGET, 2'($urandom_range(0, 3)),
								1'($urandom_range(0, 1)), $urandom);
						else
							add_event(cms_pkg::ACT_COUNTED, 2'($urandom_range(0, 3)),
								1'($urandom_range(0, 1)), rand_steps());
					end
				end
				6: add_event(cms_pkg::ACT_STOP, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
					$urandom);
				default: add_event(3'($urandom_range(0, 7)), 2'($urandom_range(0, 3)),
					1'($urandom_range(0, 1)), rand_steps());
			endcase
		end
	endtask

	task automatic drain_all();
		while (pending_q.size() != 0 || push || expect_q.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_config(logic [31:0] up_open, logic [31:0] closed_open,
			logic [31:0] rate);
		reg_writes_q.push_back('{cms_pkg::REG_UP_TO_OPEN, up_open});
		reg_writes_q.push_back('{cms_pkg::REG_CLOSED_TO_OPEN, closed_open});
		reg_writes_q.push_back('{cms_pkg::REG_STEP_RATE, rate});
		while (reg_writes_q.size() != 0 || cfg_valid)
			@(negedge clk);
	endtask

	initial begin
		cur_pos = cms_pkg::POS_UNKNOWN;
		run_busy = 1'b0;
		run_done = 1'b0;
		run_rec = cms_pkg::MOTION_CLEAR;
		plan_head = '0;
		plan_tail = '0;
		plan_count = '0;
		cfg_up_open = cms_pkg::UP_TO_OPEN_RESET;
		cfg_closed_open = cms_pkg::CLOSED_TO_OPEN_RESET;
		cfg_rate = cms_pkg::STEP_RATE_RESET;

		repeat (11) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// directed: idle update, done while idle, queue fill, limits, stop
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_DONE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_COUNTED, cms_pkg::POS_UP, cms_pkg::DIR_REV, 32'd0);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_OPEN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_COUNTED, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, '1);
		add_event(cms_pkg::ACT_COUNTED, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_REV, 32'd1);
		add_event(cms_pkg::ACT_COUNTED, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd5);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_UP, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPPER, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_LOWER, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_DONE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_STOP, cms_pkg::POS_UP, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_OPEN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPPER, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_STOP, cms_pkg::POS_CLOSED, cms_pkg::DIR_REV, '1);
		add_event(cms_pkg::ACT_TARGET, cms_pkg::POS_OPEN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPDATE, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(cms_pkg::ACT_UPPER, cms_pkg::POS_UNKNOWN, cms_pkg::DIR_FWD, 32'd0);
		add_event(3'd7, cms_pkg::POS_CLOSED, cms_pkg::DIR_REV, '1);
		drain_all();

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				0: write_config(32'd0, '1, 32'd1);
				1: write_config('1, 32'd0, 32'd1000000);
				4: write_config(cms_pkg::UP_TO_OPEN_RESET, cms_pkg::CLOSED_TO_OPEN_RESET,
					32'(cms_pkg::STEP_RATE_RESET));
				default: write_config($urandom, $urandom_range(0, 50), $urandom_range(1, 1000000));
			endcase
			calm = (phase == 4);
			if (phase == 2) begin
				// sender holds off mid-phase until the block has fully drained
				add_random_events(45);
				drain_all();
				add_random_events(45);
			end else begin
				add_random_events(90);
			end
			drain_all();
		end

		if (expect_q.size() != 0)
			report_mismatch("items left without a result");
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
